FILE: src/meu_pkg.sv
// Package for the multi-turn encoder unwrap block.
// Holds field widths, action codes and the saturating turn adder.
// No dependencies.
package meu_pkg;

  localparam int RAW_W    = 12;
  localparam int PHASE_W  = 16;
  localparam int ANGLE_W  = 32;
  localparam int TURN_W   = 16;
  localparam int ACTION_W = 2;
  localparam int STEP_W   = 18;

  localparam int AVG_SAMPLES_DEF = 4;

  localparam logic [ACTION_W-1:0] ACT_TRACK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ZERO  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SYNC  = 2'd2;

  localparam logic signed [STEP_W-1:0] TURN_MAX = 18'sd32767;
  localparam logic signed [STEP_W-1:0] TURN_MIN = -18'sd32767;

  // Adds a signed step to the turn count and clamps to the symmetric limits.
  function automatic logic signed [TURN_W-1:0] sat_turns(
    input logic signed [TURN_W-1:0] turns,
    input logic signed [STEP_W-1:0] step
  );
    logic signed [STEP_W-1:0] sum;
    sum = STEP_W'(turns) + step;
    if (sum > TURN_MAX) begin
      sat_turns = TURN_MAX[TURN_W-1:0];
    end else if (sum < TURN_MIN) begin
      sat_turns = TURN_MIN[TURN_W-1:0];
    end else begin
      sat_turns = sum[TURN_W-1:0];
    end
  endfunction

endpackage

FILE: src/multiturn_encoder_unwrap.sv
// Multi-turn unwrap of a 12-bit absolute angle sensor.
// Depends on meu_pkg for widths, action codes and turn saturation.
//
// Usage: one input transaction carries an action, a raw 12-bit angle, a
// read-ok flag and a sync target. Tracking and zeroing samples are gathered in
// groups of AVG_SAMPLES; only the sample that completes a group gives a result
// transaction, carrying a status, the multi-turn angle and the turn count.
// A sync transaction always gives one result. Action 3 is taken and ignored.
// Samples that do not complete a group are only accumulated and give no result.
// A group-completing sample runs through the divider, the update step and the
// output step: the average is formed by one shared restoring divider that
// retires one quotient bit per cycle over the DIV_W-bit scaled sum. A group
// with no valid sample skips the divider and reports encoder fail.
// A sync transaction passes through the subtract, round and saturating add
// steps. in_ready is high only while the sequencer is idle.
// The finished result sits in an output register, so the next input
// transaction is taken while it waits; if the receiver stalls with a result
// still held, a newly finished one waits in the sequencer until it is taken.
// Synchronous reset clears the group accumulator, turns, phase and offset.
module multiturn_encoder_unwrap #(
  parameter int AVG_SAMPLES = meu_pkg::AVG_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [meu_pkg::ACTION_W-1:0]         in_action,
  input  logic [meu_pkg::RAW_W-1:0]            in_raw_angle,
  input  logic                                 in_read_ok,
  input  logic signed [meu_pkg::ANGLE_W-1:0]   in_expected_angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic signed [meu_pkg::ANGLE_W-1:0]   out_angle,
  output logic signed [meu_pkg::TURN_W-1:0]    out_turns
);
  import meu_pkg::*;

  // Sum of up to AVG_SAMPLES codes, count of valid samples, dividend width.
  localparam int SUM_W = RAW_W + $clog2(AVG_SAMPLES);
  localparam int CNT_W = $clog2(AVG_SAMPLES + 1);
  localparam int DIV_W = SUM_W + 4;
  localparam int BIT_W = $clog2(DIV_W);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_UPD, S_SYNC_D, S_SYNC_Q, S_SYNC_ADD, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0]                sample_sum_r, sample_sum_nxt;
  logic [CNT_W-1:0]                valid_count_r, valid_count_nxt;
  logic [CNT_W-1:0]                sample_index_r, sample_index_nxt;
  logic signed [TURN_W-1:0]        turn_count_r, turn_count_nxt;
  logic [PHASE_W-1:0]              last_phase_r, last_phase_nxt;
  logic [PHASE_W-1:0]              zero_offset_r, zero_offset_nxt;

  // Divider working registers; the quotient shifts in behind the dividend.
  logic [DIV_W-1:0]                dvd_r, dvd_nxt;
  logic [CNT_W-1:0]                rem_r, rem_nxt;
  logic [CNT_W-1:0]                div_cnt_r, div_cnt_nxt;
  logic [BIT_W-1:0]                bit_r, bit_nxt;

  logic                            zero_grp_r, zero_grp_nxt;
  logic                            fail_r, fail_nxt;
  logic signed [ANGLE_W-1:0]       expected_r, expected_nxt;
  logic signed [ANGLE_W:0]         diff_r, diff_nxt;
  logic signed [STEP_W-1:0]        step_r, step_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_status_r, out_status_nxt;
  logic signed [ANGLE_W-1:0]       out_angle_r, out_angle_nxt;
  logic signed [TURN_W-1:0]        out_turns_r, out_turns_nxt;

  logic signed [ANGLE_W-1:0]       cur_angle;
  logic [SUM_W-1:0]                sum_acc;
  logic [CNT_W-1:0]                cnt_acc;
  logic [CNT_W:0]                  trial;
  logic                            trial_ge;
  logic [CNT_W:0]                  trial_sub;
  logic [PHASE_W-1:0]              phase;
  logic signed [PHASE_W:0]         delta;
  logic [ANGLE_W:0]                mag;
  logic [ANGLE_W:0]                rounded;
  logic signed [STEP_W-1:0]        q_pos;

  // {turns, phase} is turns * 65536 + phase exactly; the offset result fits.
  assign cur_angle = $signed({turn_count_r, last_phase_r}) -
                     $signed({{(ANGLE_W-PHASE_W){1'b0}}, zero_offset_r});

  assign sum_acc = sample_sum_r + (in_read_ok ? SUM_W'(in_raw_angle) : SUM_W'(0));
  assign cnt_acc = valid_count_r + (in_read_ok ? CNT_W'(1) : CNT_W'(0));

  // One restoring step: the remainder always stays below the divisor.
  assign trial     = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, div_cnt_r};
  assign trial_sub = trial - {1'b0, div_cnt_r};

  // The average never exceeds 65520, so the low quotient bits hold it whole.
  assign phase = dvd_r[PHASE_W-1:0];
  assign delta = $signed({1'b0, phase}) - $signed({1'b0, last_phase_r});

  // Round half away from zero on the magnitude of the turn error.
  assign mag     = diff_r[ANGLE_W] ? -diff_r : diff_r;
  assign rounded = mag + (ANGLE_W+1)'(32768);
  assign q_pos   = $signed({1'b0, rounded[ANGLE_W:PHASE_W]});

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_angle  = out_angle_r;
  assign out_turns  = out_turns_r;

  always_comb begin
    state_nxt        = state_r;
    sample_sum_nxt   = sample_sum_r;
    valid_count_nxt  = valid_count_r;
    sample_index_nxt = sample_index_r;
    turn_count_nxt   = turn_count_r;
    last_phase_nxt   = last_phase_r;
    zero_offset_nxt  = zero_offset_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    div_cnt_nxt      = div_cnt_r;
    bit_nxt          = bit_r;
    zero_grp_nxt     = zero_grp_r;
    fail_nxt         = fail_r;
    expected_nxt     = expected_r;
    diff_nxt         = diff_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_angle_nxt    = out_angle_r;
    out_turns_nxt    = out_turns_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_SYNC) begin
            expected_nxt = in_expected_angle;
            state_nxt    = S_SYNC_D;
          end else if (in_action == ACT_TRACK || in_action == ACT_ZERO) begin
            if (sample_index_r == CNT_W'(AVG_SAMPLES - 1)) begin
              // Group complete: clear the accumulator and start the average, or flag a fail if no sample was valid.
              sample_sum_nxt   = '0;
              valid_count_nxt  = '0;
              sample_index_nxt = '0;
              zero_grp_nxt     = (in_action == ACT_ZERO);
              dvd_nxt          = {sum_acc, 4'b0000};
              rem_nxt          = '0;
              div_cnt_nxt      = cnt_acc;
              bit_nxt          = BIT_W'(DIV_W - 1);
              if (cnt_acc == '0) begin
                fail_nxt  = 1'b1;
                state_nxt = S_OUT;
              end else begin
                fail_nxt  = 1'b0;
                state_nxt = S_DIV;
              end
            end else begin
              sample_sum_nxt   = sum_acc;
              valid_count_nxt  = cnt_acc;
              sample_index_nxt = sample_index_r + CNT_W'(1);
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_nxt = {dvd_r[DIV_W-2:0], trial_ge};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (zero_grp_r) begin
          zero_offset_nxt = phase;
          last_phase_nxt  = phase;
          turn_count_nxt  = '0;
        end else begin
          // A fresh tracker (no turns, zero phase) takes the phase unchecked.
          if (!(turn_count_r == '0 && last_phase_r == '0)) begin
            if (delta > (PHASE_W+1)'(32768)) begin
              turn_count_nxt = sat_turns(turn_count_r, -STEP_W'(1));
            end else if (delta < -(PHASE_W+1)'(32768)) begin
              turn_count_nxt = sat_turns(turn_count_r, STEP_W'(1));
            end
          end
          last_phase_nxt = phase;
        end
        state_nxt = S_OUT;
      end
      S_SYNC_D: begin
        diff_nxt  = $signed({expected_r[ANGLE_W-1], expected_r}) -
                    $signed({cur_angle[ANGLE_W-1], cur_angle});
        fail_nxt  = 1'b0;
        state_nxt = S_SYNC_Q;
      end
      S_SYNC_Q: begin
        step_nxt  = diff_r[ANGLE_W] ? -q_pos : q_pos;
        state_nxt = S_SYNC_ADD;
      end
      S_SYNC_ADD: begin
        turn_count_nxt = sat_turns(turn_count_r, step_r);
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fail_r;
          out_angle_nxt  = cur_angle;
          out_turns_nxt  = turn_count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_sum_r   <= '0;
      valid_count_r  <= '0;
      sample_index_r <= '0;
      turn_count_r   <= '0;
      last_phase_r   <= '0;
      zero_offset_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_sum_r   <= sample_sum_nxt;
      valid_count_r  <= valid_count_nxt;
      sample_index_r <= sample_index_nxt;
      turn_count_r   <= turn_count_nxt;
      last_phase_r   <= last_phase_nxt;
      zero_offset_r  <= zero_offset_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    bit_r        <= bit_nxt;
    zero_grp_r   <= zero_grp_nxt;
    fail_r       <= fail_nxt;
    expected_r   <= expected_nxt;
    diff_r       <= diff_nxt;
    step_r       <= step_nxt;
    out_status_r <= out_status_nxt;
    out_angle_r  <= out_angle_nxt;
    out_turns_r  <= out_turns_nxt;
  end

endmodule
